>>> design/rmq_pkg.sv
package rmq_pkg;

    localparam int ELEM_W          = 16;               // Q2.14 element / result width
    localparam int FRAC_W          = 14;               // fraction bits of Q2.14
    localparam int SUM_W           = ELEM_W + 3;       // trace / radicand, signed
    localparam int VEC_W           = ELEM_W + 1;       // off-diagonal sum or difference
    localparam int ROOT_W          = 16;               // root bits, also quotient bits
    localparam int RAD_W           = 2 * ROOT_W;       // radicand shifted by 2^14
    localparam int REM_SQ_W        = ROOT_W + 1;       // root remainder
    localparam int LANES           = 3;                // scaled components
    localparam int STEPS_PER_STAGE = 4;
    localparam int ROOT_STAGES     = ROOT_W / STEPS_PER_STAGE;
    localparam int DIV_STAGES      = ROOT_W / STEPS_PER_STAGE;
    localparam logic signed [SUM_W-1:0] QONE = SUM_W'(1 << FRAC_W);

    typedef enum logic [1:0] {
        BR_TRACE,
        BR_X,
        BR_Y,
        BR_Z
    } rmq_branch_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] r00;
        logic signed [ELEM_W-1:0] r01;
        logic signed [ELEM_W-1:0] r02;
        logic signed [ELEM_W-1:0] r10;
        logic signed [ELEM_W-1:0] r11;
        logic signed [ELEM_W-1:0] r12;
        logic signed [ELEM_W-1:0] r20;
        logic signed [ELEM_W-1:0] r21;
        logic signed [ELEM_W-1:0] r22;
    } rmq_in_t;

    typedef struct packed {
        logic signed [ELEM_W-1:0] quat_w;
        logic signed [ELEM_W-1:0] quat_x;
        logic signed [ELEM_W-1:0] quat_y;
        logic signed [ELEM_W-1:0] quat_z;
    } rmq_out_t;

    // root pipeline word
    typedef struct packed {
        rmq_branch_t                   branch;
        logic [LANES-1:0][VEC_W-1:0]   vec;
        logic [RAD_W-1:0]              rad;
        logic [REM_SQ_W-1:0]           rem;
        logic [ROOT_W-1:0]             root;
    } rmq_sq_t;

    // one divider lane
    typedef struct packed {
        logic              neg;
        logic              ovf;
        logic [ROOT_W-1:0] rem;
        logic [ROOT_W-1:0] quo;
        logic [ROOT_W-1:0] dsh;
    } rmq_lane_t;

    typedef struct packed {
        rmq_branch_t                 branch;
        logic [ROOT_W-1:0]           root;
        rmq_lane_t [LANES-1:0]       lane;
    } rmq_dv_t;

endpackage

>>> design/rmq_front.sv
module rmq_front (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rmq_pkg::rmq_in_t in_data,
    output logic             in_stall,
    output logic             out_valid,
    output rmq_pkg::rmq_sq_t out_data,
    input  logic             out_stall
);
    import rmq_pkg::*;

    logic signed [SUM_W-1:0] e00, e01, e02, e10, e11, e12, e20, e21, e22;
    logic signed [SUM_W-1:0] tr;
    logic signed [SUM_W-1:0] p;
    rmq_sq_t                 d_next;
    rmq_sq_t                 d_reg;
    logic                    v_reg;

    assign in_stall  = v_reg && out_stall;
    assign out_valid = v_reg;
    assign out_data  = d_reg;

    always_comb
    begin
        e00 = SUM_W'(in_data.r00);
        e01 = SUM_W'(in_data.r01);
        e02 = SUM_W'(in_data.r02);
        e10 = SUM_W'(in_data.r10);
        e11 = SUM_W'(in_data.r11);
        e12 = SUM_W'(in_data.r12);
        e20 = SUM_W'(in_data.r20);
        e21 = SUM_W'(in_data.r21);
        e22 = SUM_W'(in_data.r22);
        tr  = e00 + e11 + e22;

        d_next      = '0;
        d_next.root = '0;
        d_next.rem  = '0;
        priority if (tr > 0)
        begin
            d_next.branch = BR_TRACE;
            p = QONE + tr;
            d_next.vec[0] = VEC_W'(e21 - e12);
            d_next.vec[1] = VEC_W'(e02 - e20);
            d_next.vec[2] = VEC_W'(e10 - e01);
        end
        else if (e11 > e00 && e11 > e22)
        begin
            d_next.branch = BR_Y;
            p = QONE + e11 - e00 - e22;
            d_next.vec[0] = VEC_W'(e02 - e20);
            d_next.vec[1] = VEC_W'(e10 + e01);
            d_next.vec[2] = VEC_W'(e21 + e12);
        end
        else if (e22 > e00)
        begin
            d_next.branch = BR_Z;
            p = QONE + e22 - e00 - e11;
            d_next.vec[0] = VEC_W'(e10 - e01);
            d_next.vec[1] = VEC_W'(e02 + e20);
            d_next.vec[2] = VEC_W'(e21 + e12);
        end
        else
        begin
            d_next.branch = BR_X;
            p = QONE + e00 - e11 - e22;
            d_next.vec[0] = VEC_W'(e21 - e12);
            d_next.vec[1] = VEC_W'(e10 + e01);
            d_next.vec[2] = VEC_W'(e02 + e20);
        end
        // negative radicand clamps to a zero root
        if (p > 0)
        begin
            d_next.rad = {1'b0, p[VEC_W-1:0], {FRAC_W{1'b0}}};
        end
        else
        begin
            d_next.rad = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            v_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!in_stall)
        begin
            d_reg <= d_next;
        end
    end

endmodule

>>> design/rmq_sqrt.sv
module rmq_sqrt (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rmq_pkg::rmq_sq_t in_data,
    output logic             in_stall,
    output logic             out_valid,
    output rmq_pkg::rmq_sq_t out_data,
    input  logic             out_stall
);
    import rmq_pkg::*;

    // four bit-pair steps of the restoring square root
    function automatic rmq_sq_t sq_steps(input rmq_sq_t d);
        rmq_sq_t               r;
        logic [REM_SQ_W+1:0]   trial;
        logic [ROOT_W+1:0]     sub;
        r = d;
        for (int i = 0; i < STEPS_PER_STAGE; i++)
        begin
            trial = {r.rem, r.rad[RAD_W-1 -: 2]};
            sub   = {r.root, 2'b01};
            r.rad = {r.rad[RAD_W-3:0], 2'b00};
            if (trial >= (REM_SQ_W+2)'(sub))
            begin
                r.rem  = REM_SQ_W'(trial - (REM_SQ_W+2)'(sub));
                r.root = {r.root[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                r.rem  = REM_SQ_W'(trial);
                r.root = {r.root[ROOT_W-2:0], 1'b0};
            end
        end
        return r;
    endfunction

    logic                 v_reg  [ROOT_STAGES];
    rmq_sq_t              d_reg  [ROOT_STAGES];
    rmq_sq_t              d_next [ROOT_STAGES];
    rmq_sq_t              src    [ROOT_STAGES];
    logic                 src_v  [ROOT_STAGES];
    logic [ROOT_STAGES:0] stall_chain;

    always_comb
    begin
        stall_chain[ROOT_STAGES] = out_stall;
        for (int k = ROOT_STAGES - 1; k >= 0; k--)
        begin
            stall_chain[k] = v_reg[k] && stall_chain[k+1];
        end
        src[0]   = in_data;
        src_v[0] = in_valid;
        for (int k = 1; k < ROOT_STAGES; k++)
        begin
            src[k]   = d_reg[k-1];
            src_v[k] = v_reg[k-1];
        end
        for (int k = 0; k < ROOT_STAGES; k++)
        begin
            d_next[k] = sq_steps(src[k]);
        end
    end

    assign in_stall  = stall_chain[0];
    assign out_valid = v_reg[ROOT_STAGES-1];
    assign out_data  = d_reg[ROOT_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < ROOT_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < ROOT_STAGES; k++)
            begin
                if (!stall_chain[k])
                begin
                    v_reg[k] <= src_v[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < ROOT_STAGES; k++)
        begin
            if (!stall_chain[k])
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

endmodule

>>> design/rmq_div.sv
module rmq_div (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  rmq_pkg::rmq_sq_t in_data,
    output logic             in_stall,
    output logic             out_valid,
    output rmq_pkg::rmq_dv_t out_data,
    input  logic             out_stall
);
    import rmq_pkg::*;

    // four restoring steps on each lane, shared divisor
    function automatic rmq_dv_t dv_steps(input rmq_dv_t d);
        rmq_dv_t         r;
        logic [ROOT_W:0] t;
        r = d;
        for (int l = 0; l < LANES; l++)
        begin
            for (int i = 0; i < STEPS_PER_STAGE; i++)
            begin
                t = {r.lane[l].rem, r.lane[l].dsh[ROOT_W-1]};
                r.lane[l].dsh = {r.lane[l].dsh[ROOT_W-2:0], 1'b0};
                if (t >= {1'b0, r.root})
                begin
                    r.lane[l].rem = ROOT_W'(t - {1'b0, r.root});
                    r.lane[l].quo = {r.lane[l].quo[ROOT_W-2:0], 1'b1};
                end
                else
                begin
                    r.lane[l].rem = t[ROOT_W-1:0];
                    r.lane[l].quo = {r.lane[l].quo[ROOT_W-2:0], 1'b0};
                end
            end
        end
        return r;
    endfunction

    rmq_dv_t             entry;
    logic [VEC_W-1:0]    mag [LANES];
    logic                v_reg  [DIV_STAGES];
    rmq_dv_t             d_reg  [DIV_STAGES];
    rmq_dv_t             d_next [DIV_STAGES];
    rmq_dv_t             src    [DIV_STAGES];
    logic                src_v  [DIV_STAGES];
    logic [DIV_STAGES:0] stall_chain;

    // magnitude and sign; quotient >= 2^15 exactly when mag >= 4*root
    always_comb
    begin
        entry.branch = in_data.branch;
        entry.root   = in_data.root;
        for (int l = 0; l < LANES; l++)
        begin
            entry.lane[l].neg = in_data.vec[l][VEC_W-1];
            mag[l] = entry.lane[l].neg ? VEC_W'(-in_data.vec[l]) : in_data.vec[l];
            entry.lane[l].ovf = {1'b0, mag[l]} >= {in_data.root, 2'b00};
            entry.lane[l].rem = ROOT_W'(mag[l] >> 3);
            entry.lane[l].quo = '0;
            entry.lane[l].dsh = {mag[l][2:0], {(ROOT_W-3){1'b0}}};
        end
    end

    always_comb
    begin
        stall_chain[DIV_STAGES] = out_stall;
        for (int k = DIV_STAGES - 1; k >= 0; k--)
        begin
            stall_chain[k] = v_reg[k] && stall_chain[k+1];
        end
        src[0]   = entry;
        src_v[0] = in_valid;
        for (int k = 1; k < DIV_STAGES; k++)
        begin
            src[k]   = d_reg[k-1];
            src_v[k] = v_reg[k-1];
        end
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            d_next[k] = dv_steps(src[k]);
        end
    end

    assign in_stall  = stall_chain[0];
    assign out_valid = v_reg[DIV_STAGES-1];
    assign out_data  = d_reg[DIV_STAGES-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                v_reg[k] <= 1'b0;
            end
        end
        else
        begin
            for (int k = 0; k < DIV_STAGES; k++)
            begin
                if (!stall_chain[k])
                begin
                    v_reg[k] <= src_v[k];
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int k = 0; k < DIV_STAGES; k++)
        begin
            if (!stall_chain[k])
            begin
                d_reg[k] <= d_next[k];
            end
        end
    end

`ifndef ASSERT_OFF
    // no overflow flagged: quotient fits in 15 bits
    a_quo_range: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> ((out_data.lane[0].ovf || !out_data.lane[0].quo[ROOT_W-1]) &&
                       (out_data.lane[1].ovf || !out_data.lane[1].quo[ROOT_W-1]) &&
                       (out_data.lane[2].ovf || !out_data.lane[2].quo[ROOT_W-1])))
        else $error("divider quotient out of range");

    // restoring remainder stays below the divisor
    a_rem_range: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_data.root != '0) |->
            ((out_data.lane[0].ovf || out_data.lane[0].rem < out_data.root) &&
             (out_data.lane[1].ovf || out_data.lane[1].rem < out_data.root) &&
             (out_data.lane[2].ovf || out_data.lane[2].rem < out_data.root)))
        else $error("divider remainder not below divisor");

    // back-pressure only reaches the input when the last stage is full
    a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (out_valid && out_stall))
        else $error("divider stalled with empty output stage");
`endif

endmodule

>>> design/rotation_matrix_to_quaternion.sv
// Channel   Payload   Valid        Stall        Direction
// matrix    mat       mat_valid    mat_stall    in  (9 x Q2.14)
// quat      quat      quat_valid   quat_stall   out (4 x Q2.14, saturated)
//
// Throughput one matrix per cycle while quat_stall is low; stages: 1 decode,
// 4 root, 4 divide, 1 output; each root/divide stage retires 4 bits, setting depth.
// Reset clears only valid bits; data registers are not reset.
// Stalls propagate stage by stage: an empty stage keeps loading, so bubbles
// collapse and the input is stalled only when every stage is occupied.
module rotation_matrix_to_quaternion (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              mat_valid,
    input  rmq_pkg::rmq_in_t  mat,
    output logic              mat_stall,
    output logic              quat_valid,
    output rmq_pkg::rmq_out_t quat,
    input  logic              quat_stall
);
    import rmq_pkg::*;

    // decode -> root transaction
    logic     fr_valid;
    logic     fr_stall;
    rmq_sq_t  fr_data;
    // root -> divide transaction
    logic     sq_valid;
    logic     sq_stall;
    rmq_sq_t  sq_data;
    // divide -> output transaction
    logic     dv_valid;
    logic     dv_stall;
    rmq_dv_t  dv_data;

    logic [ELEM_W-1:0] half;
    logic [ELEM_W-1:0] comp [LANES];
    rmq_out_t          quat_next;
    rmq_out_t          quat_reg;
    logic              quat_valid_reg;

    // trace test, branch pick, radicand and off-diagonal terms
    rmq_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (mat_valid),
        .in_data   (mat),
        .in_stall  (mat_stall),
        .out_valid (fr_valid),
        .out_data  (fr_data),
        .out_stall (fr_stall)
    );

    // floor(sqrt(P * 2^14))
    rmq_sqrt u_sqrt (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (fr_valid),
        .in_data   (fr_data),
        .in_stall  (fr_stall),
        .out_valid (sq_valid),
        .out_data  (sq_data),
        .out_stall (sq_stall)
    );

    // |v| * 2^13 / root on three lanes
    rmq_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (sq_valid),
        .in_data   (sq_data),
        .in_stall  (sq_stall),
        .out_valid (dv_valid),
        .out_data  (dv_data),
        .out_stall (dv_stall)
    );

    assign dv_stall = quat_valid_reg && quat_stall;

    // sign, saturation, zero-root rule, then route by branch
    always_comb
    begin
        half = {1'b0, dv_data.root[ROOT_W-1:1]};
        for (int l = 0; l < LANES; l++)
        begin
            if (dv_data.root == '0)
            begin
                comp[l] = '0;
            end
            else if (dv_data.lane[l].ovf)
            begin
                comp[l] = dv_data.lane[l].neg ? {1'b1, {(ELEM_W-1){1'b0}}}
                                              : {1'b0, {(ELEM_W-1){1'b1}}};
            end
            else
            begin
                comp[l] = dv_data.lane[l].neg ? ELEM_W'(-dv_data.lane[l].quo)
                                              : ELEM_W'(dv_data.lane[l].quo);
            end
        end
        unique case (dv_data.branch)
            BR_TRACE:
            begin
                quat_next.quat_w = half;
                quat_next.quat_x = comp[0];
                quat_next.quat_y = comp[1];
                quat_next.quat_z = comp[2];
            end
            BR_X:
            begin
                quat_next.quat_w = comp[0];
                quat_next.quat_x = half;
                quat_next.quat_y = comp[1];
                quat_next.quat_z = comp[2];
            end
            BR_Y:
            begin
                quat_next.quat_w = comp[0];
                quat_next.quat_x = comp[1];
                quat_next.quat_y = half;
                quat_next.quat_z = comp[2];
            end
            BR_Z:
            begin
                quat_next.quat_w = comp[0];
                quat_next.quat_x = comp[1];
                quat_next.quat_y = comp[2];
                quat_next.quat_z = half;
            end
            default:
            begin
                quat_next = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quat_valid_reg <= 1'b0;
        end
        else if (!dv_stall)
        begin
            quat_valid_reg <= dv_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!dv_stall)
        begin
            quat_reg <= quat_next;
        end
    end

    assign quat_valid = quat_valid_reg;
    assign quat       = quat_reg;

endmodule

>>> sim/tb_top.sv
`timescale 1ns / 100ps

// Rotation-matrix-to-quaternion testbench.
// A driver always block feeds matrices from a pending queue, a monitor always
// block checks each quaternion transaction against a locally computed
// prediction (Shepperd branch select, integer root, scaled divide, saturation).
module tb_top;
    import rmq_pkg::*;

    localparam int LATENCY         = 10;
    localparam int MAX_CYCLES      = 400000;
    localparam int HOLD_OFF_CYCLES = 60;

    logic     clk;
    logic     rst_n;
    logic     mat_valid;
    rmq_in_t  mat;
    logic     mat_stall;
    logic     quat_valid;
    rmq_out_t quat;
    logic     quat_stall;

    rotation_matrix_to_quaternion dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .mat_valid  (mat_valid),
        .mat        (mat),
        .mat_stall  (mat_stall),
        .quat_valid (quat_valid),
        .quat       (quat),
        .quat_stall (quat_stall)
    );

    rmq_in_t  pending_mats[$];
    rmq_out_t expected_quats[$];
    int       send_idle_pct;
    int       recv_idle_pct;
    int       hold_off_cycles = 0;   // receiver hold-off, counted down by the receiver
    int       hold_off_req    = 0;   // hold-off requests from the sequence
    int       hold_off_done   = 0;   // hold-off requests taken up by the receiver
    bit       sender_pause;          // sender waits for the pipe to drain
    int       errors          = 0;
    int       cycle_count     = 0;
    int       quats_checked   = 0;
    int       branch_hits[4];

    initial
    begin
        clk = 1'b0;
    end

    always #6 clk = ~clk;

    // ---------------------------------------------------------------
    // Prediction
    // ---------------------------------------------------------------
    function automatic longint unsigned int_sqrt(longint unsigned n);
        longint unsigned res;
        longint unsigned bitv;
        res  = 0;
        bitv = 64'd1 << 62;
        while (bitv > n)
            bitv >>= 2;
        while (bitv != 0)
        begin
            if (n >= res + bitv)
            begin
                n   -= res + bitv;
                res  = (res >> 1) + bitv;
            end
            else
                res >>= 1;
            bitv >>= 2;
        end
        return res;
    endfunction

    function automatic longint sat_q14(longint v);
        if (v > 32767)
            return 32767;
        if (v < -32768)
            return -32768;
        return v;
    endfunction

    // root in Q.14 of a clamped radicand
    function automatic longint unsigned root_of(longint p);
        if (p <= 0)
            return 0;
        return int_sqrt(longint'(p) << 14);
    endfunction

    function automatic longint scaled_part(longint v, longint unsigned s);
        longint unsigned mag;
        if (s == 0)
            return 0;
        mag = (v < 0) ? -v : v;
        mag = (mag << 13) / s;
        if (mag > 65536)
            mag = 65536;
        return sat_q14((v < 0) ? -longint'(mag) : longint'(mag));
    endfunction

    function automatic rmq_out_t predict_quat(rmq_in_t m, output rmq_branch_t br);
        longint a00, a01, a02, a10, a11, a12, a20, a21, a22;
        longint tr, w, x, y, z;
        longint unsigned s;
        rmq_out_t q;
        a00 = m.r00; a01 = m.r01; a02 = m.r02;
        a10 = m.r10; a11 = m.r11; a12 = m.r12;
        a20 = m.r20; a21 = m.r21; a22 = m.r22;
        tr = a00 + a11 + a22;
        if (tr > 0)
        begin
            br = BR_TRACE;
            s  = root_of(tr + 16384);
            w  = sat_q14(longint'(s >> 1));
            x  = scaled_part(a21 - a12, s);
            y  = scaled_part(a02 - a20, s);
            z  = scaled_part(a10 - a01, s);
        end
        else if (a11 > a00 && a11 > a22)
        begin
            br = BR_Y;
            s  = root_of(a11 - a00 - a22 + 16384);
            y  = sat_q14(longint'(s >> 1));
            w  = scaled_part(a02 - a20, s);
            x  = scaled_part(a10 + a01, s);
            z  = scaled_part(a21 + a12, s);
        end
        else if (a22 > a00)
        begin
            br = BR_Z;
            s  = root_of(a22 - a00 - a11 + 16384);
            z  = sat_q14(longint'(s >> 1));
            w  = scaled_part(a10 - a01, s);
            x  = scaled_part(a02 + a20, s);
            y  = scaled_part(a21 + a12, s);
        end
        else
        begin
            br = BR_X;
            s  = root_of(a00 - a11 - a22 + 16384);
            x  = sat_q14(longint'(s >> 1));
            w  = scaled_part(a21 - a12, s);
            y  = scaled_part(a10 + a01, s);
            z  = scaled_part(a02 + a20, s);
        end
        q.quat_w = w[15:0];
        q.quat_x = x[15:0];
        q.quat_y = y[15:0];
        q.quat_z = z[15:0];
        return q;
    endfunction

    // ---------------------------------------------------------------
    // Stimulus helpers
    // ---------------------------------------------------------------
    function automatic logic signed [15:0] rand_elem();
        case ($urandom_range(0, 9))
            0:       return 16'sh8000;
            1:       return 16'sh7FFF;
            2:       return 16'sd16384;
            3:       return -16'sd16384;
            4:       return 16'sd0;
            5, 6:    return $signed(16'($urandom_range(0, 32767))) - 16'sd16384;
            default: return 16'($urandom);
        endcase
    endfunction

    // roughly valid rotation from a random unit quaternion
    function automatic rmq_in_t rand_rotation();
        real qw, qx, qy, qz, n;
        rmq_in_t m;
        qw = $signed($urandom) / 2147483648.0;
        qx = $signed($urandom) / 2147483648.0;
        qy = $signed($urandom) / 2147483648.0;
        qz = $signed($urandom) / 2147483648.0;
        n  = $sqrt(qw*qw + qx*qx + qy*qy + qz*qz) + 1e-9;
        qw /= n; qx /= n; qy /= n; qz /= n;
        m.r00 = 16'($rtoi(16384.0 * (1 - 2*(qy*qy + qz*qz))));
        m.r01 = 16'($rtoi(16384.0 * (2*(qx*qy - qz*qw))));
        m.r02 = 16'($rtoi(16384.0 * (2*(qx*qz + qy*qw))));
        m.r10 = 16'($rtoi(16384.0 * (2*(qx*qy + qz*qw))));
        m.r11 = 16'($rtoi(16384.0 * (1 - 2*(qx*qx + qz*qz))));
        m.r12 = 16'($rtoi(16384.0 * (2*(qy*qz - qx*qw))));
        m.r20 = 16'($rtoi(16384.0 * (2*(qx*qz - qy*qw))));
        m.r21 = 16'($rtoi(16384.0 * (2*(qy*qz + qx*qw))));
        m.r22 = 16'($rtoi(16384.0 * (1 - 2*(qx*qx + qy*qy))));
        return m;
    endfunction

    function automatic rmq_in_t diag_mat(int d0, int d1, int d2, int off);
        rmq_in_t m;
        m.r00 = 16'(d0); m.r11 = 16'(d1); m.r22 = 16'(d2);
        m.r01 = 16'(off); m.r02 = 16'(-off); m.r10 = 16'(off * 2);
        m.r12 = 16'(off); m.r20 = 16'(-off * 2); m.r21 = 16'(off);
        return m;
    endfunction

    task automatic add_random(int n);
        rmq_in_t m;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(0, 99) < 60)
                m = rand_rotation();
            else
                m = {rand_elem(), rand_elem(), rand_elem(), rand_elem(), rand_elem(),
                     rand_elem(), rand_elem(), rand_elem(), rand_elem()};
            pending_mats.push_back(m);
        end
    endtask

    task automatic wait_drained();
        while (pending_mats.size() != 0 || mat_valid || expected_quats.size() != 0)
            @(posedge clk);
    endtask

    // ---------------------------------------------------------------
    // Driver: offers the next matrix at the falling edge
    // ---------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mat_valid <= 1'b0;
            mat       <= '0;
        end
        else if (!(mat_valid && mat_stall))
        begin
            // previous transaction done (or none offered): pick the next one
            if (pending_mats.size() != 0 && !sender_pause
                && $urandom_range(0, 99) >= send_idle_pct)
            begin
                mat_valid <= 1'b1;
                mat       <= pending_mats.pop_front();
            end
            else
                mat_valid <= 1'b0;
        end
    end

    // accepted input -> prediction
    always @(posedge clk)
    begin
        rmq_branch_t br;
        if (rst_n && mat_valid && !mat_stall)
        begin
            expected_quats.push_back(predict_quat(mat, br));
            branch_hits[br]++;
        end
    end

    // ---------------------------------------------------------------
    // Receiver stall and monitor
    // ---------------------------------------------------------------
    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
            quat_stall <= 1'b0;
        else if (hold_off_req != hold_off_done)
        begin
            quat_stall      <= 1'b1;
            hold_off_cycles <= HOLD_OFF_CYCLES;
            hold_off_done   <= hold_off_req;
        end
        else if (hold_off_cycles > 0)
        begin
            quat_stall      <= 1'b1;
            hold_off_cycles <= hold_off_cycles - 1;
        end
        else
            quat_stall <= ($urandom_range(0, 99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        rmq_out_t exp_q;
        if (rst_n && quat_valid && !quat_stall)
        begin
            if (expected_quats.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected quat transaction %h", $time, quat);
            end
            else
            begin
                exp_q = expected_quats.pop_front();
                quats_checked++;
                if (quat.quat_w !== exp_q.quat_w)
                    $display("%0t: quat_w mismatch exp %0d got %0d", $time,
                             exp_q.quat_w, quat.quat_w);
                if (quat.quat_x !== exp_q.quat_x)
                    $display("%0t: quat_x mismatch exp %0d got %0d", $time,
                             exp_q.quat_x, quat.quat_x);
                if (quat.quat_y !== exp_q.quat_y)
                    $display("%0t: quat_y mismatch exp %0d got %0d", $time,
                             exp_q.quat_y, quat.quat_y);
                if (quat.quat_z !== exp_q.quat_z)
                    $display("%0t: quat_z mismatch exp %0d got %0d", $time,
                             exp_q.quat_z, quat.quat_z);
                if (quat !== exp_q)
                    errors++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > MAX_CYCLES)
        begin
            $display("timeout after %0d cycles", cycle_count);
            $display("tb_top failed");
            $finish;
        end
    end

    // ---------------------------------------------------------------
    // Test sequence
    // ---------------------------------------------------------------
    initial
    begin
        sender_pause    = 1'b0;
        send_idle_pct   = 32;
        recv_idle_pct   = 66;
        rst_n           = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: identity, each branch, zero trace, ties, negative radicand,
        // zero root, field extremes and saturating quotients
        pending_mats.push_back(diag_mat(16384, 16384, 16384, 0));
        pending_mats.push_back(diag_mat(16384, -16384, -16384, 100));
        pending_mats.push_back(diag_mat(-16384, 16384, -16384, 100));
        pending_mats.push_back(diag_mat(-16384, -16384, 16384, 100));
        pending_mats.push_back(diag_mat(0, 0, 0, 5000));
        pending_mats.push_back(diag_mat(100, -50, -50, 700));
        pending_mats.push_back(diag_mat(-100, -100, -100, 300));
        pending_mats.push_back(diag_mat(-50, 200, 200, 300));
        pending_mats.push_back(diag_mat(-300, -300, 200, 300));
        pending_mats.push_back(diag_mat(-300, 100, 100, 300));
        pending_mats.push_back(diag_mat(-32768, -32768, -32768, 32767));
        pending_mats.push_back(diag_mat(-32768, 32767, 32767, 32767));
        pending_mats.push_back(diag_mat(-20000, -20000, 1, -32768));
        pending_mats.push_back(diag_mat(32767, 32767, 32767, -32768));
        pending_mats.push_back(diag_mat(1, 0, 0, 32767));
        pending_mats.push_back(diag_mat(0, 0, -1, 1));
        pending_mats.push_back('1);
        pending_mats.push_back({9{16'sh8000}});
        pending_mats.push_back({9{16'sh7FFF}});
        pending_mats.push_back({9{16'h5555}});
        pending_mats.push_back({9{16'hAAAA}});
        wait_drained();

        // phase 1: sender idles 32%, receiver 66%
        add_random(600);
        wait_drained();

        // phase 2: swapped, with a long receiver hold-off while the sender keeps
        // offering, so the pipe fills and stalls the matrix channel
        send_idle_pct = 66;
        recv_idle_pct = 32;
        add_random(300);
        @(negedge clk);
        send_idle_pct = 0;
        hold_off_req  = hold_off_req + 1;
        while (hold_off_done != hold_off_req || hold_off_cycles > 0)
            @(posedge clk);
        send_idle_pct = 66;
        // sender pause until every expected quaternion is out
        sender_pause = 1'b1;
        while (expected_quats.size() != 0 || mat_valid)
            @(posedge clk);
        sender_pause = 1'b0;
        add_random(300);
        wait_drained();

        // phase 3: no idling on either side
        send_idle_pct = 0;
        recv_idle_pct = 0;
        add_random(650);
        wait_drained();
        repeat (LATENCY + 5) @(posedge clk);

        $display("checked %0d quaternions: trace %0d, x %0d, y %0d, z %0d branches",
                 quats_checked, branch_hits[BR_TRACE], branch_hits[BR_X],
                 branch_hits[BR_Y], branch_hits[BR_Z]);
        if (errors == 0 && expected_quats.size() == 0)
            $display("tb_top passed");
        else
            $display("tb_top failed");
        $finish;
    end
endmodule
